@@ sv/assert_macros.svh @@
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a complete property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/cfpd_pkg.sv @@
// Shared types, codes, constants and the CRC function of the packet deframer.
package cfpd_pkg;

   localparam int PAYLOAD_DEPTH_DEFAULT = 64;

   localparam int BYTE_W           = 8;
   localparam int SEQUENCE_W       = 16;
   localparam int LENGTH_W         = 16;
   localparam int STATUS_W         = 2;
   localparam int PAYLOAD_LENGTH_W = 7;
   localparam int BYTE_INDEX_W     = 6;
   localparam int MAX_PAYLOAD_W    = 7;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 4;
   localparam int REG_INDEX_W      = 2;

   // Register indexes on the configuration port.
   localparam logic [REG_INDEX_W-1:0] REG_START_FIRST  = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_START_SECOND = 2'd1;
   localparam logic [REG_INDEX_W-1:0] REG_MAX_PAYLOAD  = 2'd2;

   localparam logic [BYTE_W-1:0]        START_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0]        START_SECOND_RESET = 8'h55;
   localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET  = 7'd64;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd2;

   // Kinds of result that the controller asks the datapath to load.
   localparam int EMIT_W = 3;
   localparam logic [EMIT_W-1:0] EMIT_NONE    = 3'd0;
   localparam logic [EMIT_W-1:0] EMIT_LEN_ERR = 3'd1;
   localparam logic [EMIT_W-1:0] EMIT_CRC_ERR = 3'd2;
   localparam logic [EMIT_W-1:0] EMIT_EMPTY   = 3'd3;
   localparam logic [EMIT_W-1:0] EMIT_PAYLOAD = 3'd4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic              clr_count;
      logic              inc_count;
      logic              hdr_load;
      logic              crc_init;
      logic              crc_upd;
      logic              store_byte;
      logic              crc_low_load;
      logic              idx_clr;
      logic              idx_inc;
      logic [EMIT_W-1:0] emit;
   } cfpd_cmd_type;

   typedef struct packed {
      logic match_first;
      logic match_second;
      logic cnt_is_six;
      logic len_exceed;
      logic cnt_lt_len;
      logic cnt_eq_len;
      logic crc_ok;
      logic len_zero;
      logic idx_last;
      logic out_free;
   } cfpd_stat_type;

   // CRC-16/CCITT-FALSE update over one byte, most significant bit first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [BYTE_W-1:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ sv/cfpd_ctrl.sv @@
// Frame parsing controller: hunts, walks header and body, sequences the readout.
`include "assert_macros.svh"

module cfpd_ctrl
   import cfpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  cfpd_stat_type stat,
   output cfpd_cmd_type  cmd
);

   localparam logic [2:0] S_HUNT1  = 3'd0;
   localparam logic [2:0] S_HUNT2  = 3'd1;
   localparam logic [2:0] S_HEADER = 3'd2;
   localparam logic [2:0] S_BODY   = 3'd3;
   localparam logic [2:0] S_FETCH  = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       readout;
   logic       result_possible;
   logic       accept;

   assign readout = (state_ff == S_FETCH) || (state_ff == S_EMIT);

   // Only the last header byte and the second CRC byte can produce a result,
   // so other bytes are taken even while the output register is occupied.
   assign result_possible = ((state_ff == S_HEADER) && stat.cnt_is_six) ||
                            ((state_ff == S_BODY) && !stat.cnt_lt_len && !stat.cnt_eq_len);

   assign req_stall = readout || (result_possible && !stat.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit = EMIT_NONE;
      unique case (state_ff)
         S_HUNT1: begin
            if (accept && stat.match_first) begin
               state_in = S_HUNT2;
            end
         end
         S_HUNT2: begin
            if (accept) begin
               if (stat.match_second) begin
                  state_in      = S_HEADER;
                  cmd.clr_count = 1'b1;
                  cmd.crc_init  = 1'b1;
               end else if (!stat.match_first) begin
                  state_in = S_HUNT1;
               end
            end
         end
         S_HEADER: begin
            if (accept) begin
               cmd.hdr_load = 1'b1;
               cmd.crc_upd  = 1'b1;
               if (!stat.cnt_is_six) begin
                  cmd.inc_count = 1'b1;
               end else if (stat.len_exceed) begin
                  cmd.emit = EMIT_LEN_ERR;
                  state_in = S_HUNT1;
               end else begin
                  cmd.clr_count = 1'b1;
                  state_in      = S_BODY;
               end
            end
         end
         S_BODY: begin
            if (accept) begin
               if (stat.cnt_lt_len) begin
                  cmd.store_byte = 1'b1;
                  cmd.crc_upd    = 1'b1;
                  cmd.inc_count  = 1'b1;
               end else if (stat.cnt_eq_len) begin
                  cmd.crc_low_load = 1'b1;
                  cmd.inc_count    = 1'b1;
               end else if (!stat.crc_ok) begin
                  cmd.emit = EMIT_CRC_ERR;
                  state_in = S_HUNT1;
               end else if (stat.len_zero) begin
                  cmd.emit = EMIT_EMPTY;
                  state_in = S_HUNT1;
               end else begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = EMIT_PAYLOAD;
               if (stat.idx_last) begin
                  state_in = S_HUNT1;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_HUNT1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT1;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_IMPLIES(a_emit_needs_room, clock, reset, cmd.emit != EMIT_NONE, stat.out_free, "result loaded while output register is full")
   `ASSERT_ALWAYS(a_fetch_then_emit, clock, reset, state_ff == S_FETCH |=> state_ff == S_EMIT, "payload fetch not followed by emit")

endmodule

@@ sv/cfpd_dp.sv @@
// Deframer datapath: header registers, CRC, payload memory and output register.
`include "assert_macros.svh"

module cfpd_dp
   import cfpd_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic [BYTE_W-1:0]           data_byte,
   input  logic [BYTE_W-1:0]           start_first,
   input  logic [BYTE_W-1:0]           start_second,
   input  logic [MAX_PAYLOAD_W-1:0]    max_payload,
   input  cfpd_cmd_type                cmd,
   output cfpd_stat_type               stat,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [BYTE_W-1:0]           rsp_version,
   output logic [BYTE_W-1:0]           rsp_message_type,
   output logic [BYTE_W-1:0]           rsp_frame_flags,
   output logic [SEQUENCE_W-1:0]       rsp_sequence_res,
   output logic [PAYLOAD_LENGTH_W-1:0] rsp_payload_length,
   output logic [BYTE_W-1:0]           rsp_payload_byte,
   output logic [BYTE_INDEX_W-1:0]     rsp_byte_index,
   output logic                        rsp_has_byte,
   output logic                        rsp_last
);

   localparam int IDX_W  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int CNT_RAW = $clog2(PAYLOAD_DEPTH + 2);
   localparam int CNT_W  = (CNT_RAW > 3) ? CNT_RAW : 3;

   // Header byte positions after the start bytes.
   localparam logic [CNT_W-1:0] HDR_VERSION = CNT_W'(0);
   localparam logic [CNT_W-1:0] HDR_TYPE    = CNT_W'(1);
   localparam logic [CNT_W-1:0] HDR_FLAGS   = CNT_W'(2);
   localparam logic [CNT_W-1:0] HDR_SEQ_LO  = CNT_W'(3);
   localparam logic [CNT_W-1:0] HDR_SEQ_HI  = CNT_W'(4);
   localparam logic [CNT_W-1:0] HDR_LEN_LO  = CNT_W'(5);
   localparam logic [CNT_W-1:0] HDR_LEN_HI  = CNT_W'(6);

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [BYTE_W-1:0]     version_ff, version_in;
   logic [BYTE_W-1:0]     msg_type_ff, msg_type_in;
   logic [BYTE_W-1:0]     flags_ff, flags_in;
   logic [SEQUENCE_W-1:0] seq_ff, seq_in;
   logic [BYTE_W-1:0]     len_lo_ff, len_lo_in;
   logic [CNT_W-1:0]      len_ff, len_in;
   logic [15:0]           crc_ff, crc_in;
   logic [BYTE_W-1:0]     crc_low_ff, crc_low_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [BYTE_W-1:0]     rd_data_ff;
   logic [BYTE_W-1:0]     mem [PAYLOAD_DEPTH];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]           rsp_version_ff, rsp_version_in;
   logic [BYTE_W-1:0]           rsp_message_type_ff, rsp_message_type_in;
   logic [BYTE_W-1:0]           rsp_frame_flags_ff, rsp_frame_flags_in;
   logic [SEQUENCE_W-1:0]       rsp_sequence_res_ff, rsp_sequence_res_in;
   logic [PAYLOAD_LENGTH_W-1:0] rsp_payload_length_ff, rsp_payload_length_in;
   logic [BYTE_W-1:0]           rsp_payload_byte_ff, rsp_payload_byte_in;
   logic [BYTE_INDEX_W-1:0]     rsp_byte_index_ff, rsp_byte_index_in;
   logic                        rsp_has_byte_ff, rsp_has_byte_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [LENGTH_W-1:0]      len_next;
   logic [MAX_PAYLOAD_W-1:0] limit;

   assign len_next = {data_byte, len_lo_ff};
   assign limit    = (max_payload > MAX_PAYLOAD_W'(PAYLOAD_DEPTH)) ?
                     MAX_PAYLOAD_W'(PAYLOAD_DEPTH) : max_payload;

   always_comb begin
      stat.match_first  = (data_byte == start_first);
      stat.match_second = (data_byte == start_second);
      stat.cnt_is_six   = (count_ff == HDR_LEN_HI);
      stat.len_exceed   = (len_next > {{(LENGTH_W - MAX_PAYLOAD_W){1'b0}}, limit});
      stat.cnt_lt_len   = (count_ff < len_ff);
      stat.cnt_eq_len   = (count_ff == len_ff);
      stat.crc_ok       = ({data_byte, crc_low_ff} == crc_ff);
      stat.len_zero     = (len_ff == '0);
      stat.idx_last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == len_ff);
      stat.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // Parsing registers.
   always_comb begin
      count_in    = count_ff;
      version_in  = version_ff;
      msg_type_in = msg_type_ff;
      flags_in    = flags_ff;
      seq_in      = seq_ff;
      len_lo_in   = len_lo_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      crc_low_in  = crc_low_ff;
      idx_in      = idx_ff;

      if (cmd.clr_count) begin
         count_in = '0;
      end else if (cmd.inc_count) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.crc_init) begin
         crc_in = CRC_INIT;
      end else if (cmd.crc_upd) begin
         crc_in = crc16_byte(crc_ff, data_byte);
      end

      if (cmd.hdr_load) begin
         unique case (count_ff)
            HDR_VERSION: version_in  = data_byte;
            HDR_TYPE:    msg_type_in = data_byte;
            HDR_FLAGS:   flags_in    = data_byte;
            HDR_SEQ_LO:  seq_in      = {seq_ff[15:8], data_byte};
            HDR_SEQ_HI:  seq_in      = {data_byte, seq_ff[7:0]};
            HDR_LEN_LO:  len_lo_in   = data_byte;
            default:     len_in      = len_next[CNT_W-1:0];
         endcase
      end

      if (cmd.crc_low_load) begin
         crc_low_in = data_byte;
      end

      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      version_ff  <= version_in;
      msg_type_ff <= msg_type_in;
      flags_ff    <= flags_in;
      seq_ff      <= seq_in;
      len_lo_ff   <= len_lo_in;
      len_ff      <= len_in;
      crc_ff      <= crc_in;
      crc_low_ff  <= crc_low_in;
      idx_ff      <= idx_in;
   end

   // Payload memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         mem[count_ff[IDX_W-1:0]] <= data_byte;
      end
      rd_data_ff <= mem[idx_ff];
   end

   // Output register.
   always_comb begin
      rsp_valid_in          = rsp_valid_ff;
      rsp_status_in         = rsp_status_ff;
      rsp_version_in        = rsp_version_ff;
      rsp_message_type_in   = rsp_message_type_ff;
      rsp_frame_flags_in    = rsp_frame_flags_ff;
      rsp_sequence_res_in   = rsp_sequence_res_ff;
      rsp_payload_length_in = rsp_payload_length_ff;
      rsp_payload_byte_in   = rsp_payload_byte_ff;
      rsp_byte_index_in     = rsp_byte_index_ff;
      rsp_has_byte_in       = rsp_has_byte_ff;
      rsp_last_in           = rsp_last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in          = 1'b1;
         rsp_status_in         = ST_GOOD;
         rsp_version_in        = '0;
         rsp_message_type_in   = '0;
         rsp_frame_flags_in    = '0;
         rsp_sequence_res_in   = '0;
         rsp_payload_length_in = '0;
         rsp_payload_byte_in   = '0;
         rsp_byte_index_in     = '0;
         rsp_has_byte_in       = 1'b0;
         rsp_last_in           = 1'b1;
         case (cmd.emit)
            EMIT_LEN_ERR: rsp_status_in = ST_LEN_ERR;
            EMIT_CRC_ERR: rsp_status_in = ST_CRC_ERR;
            EMIT_EMPTY: begin
               rsp_version_in      = version_ff;
               rsp_message_type_in = msg_type_ff;
               rsp_frame_flags_in  = flags_ff;
               rsp_sequence_res_in = seq_ff;
            end
            EMIT_PAYLOAD: begin
               rsp_version_in        = version_ff;
               rsp_message_type_in   = msg_type_ff;
               rsp_frame_flags_in    = flags_ff;
               rsp_sequence_res_in   = seq_ff;
               rsp_payload_length_in = PAYLOAD_LENGTH_W'(len_ff);
               rsp_payload_byte_in   = rd_data_ff;
               rsp_byte_index_in     = BYTE_INDEX_W'(idx_ff);
               rsp_has_byte_in       = 1'b1;
               rsp_last_in           = stat.idx_last;
            end
            default: rsp_status_in = ST_GOOD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff         <= rsp_status_in;
      rsp_version_ff        <= rsp_version_in;
      rsp_message_type_ff   <= rsp_message_type_in;
      rsp_frame_flags_ff    <= rsp_frame_flags_in;
      rsp_sequence_res_ff   <= rsp_sequence_res_in;
      rsp_payload_length_ff <= rsp_payload_length_in;
      rsp_payload_byte_ff   <= rsp_payload_byte_in;
      rsp_byte_index_ff     <= rsp_byte_index_in;
      rsp_has_byte_ff       <= rsp_has_byte_in;
      rsp_last_ff           <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_version        = rsp_version_ff;
   assign rsp_message_type   = rsp_message_type_ff;
   assign rsp_frame_flags    = rsp_frame_flags_ff;
   assign rsp_sequence_res   = rsp_sequence_res_ff;
   assign rsp_payload_length = rsp_payload_length_ff;
   assign rsp_payload_byte   = rsp_payload_byte_ff;
   assign rsp_byte_index     = rsp_byte_index_ff;
   assign rsp_has_byte       = rsp_has_byte_ff;
   assign rsp_last           = rsp_last_ff;

   `ASSERT_IMPLIES(a_store_in_bounds, clock, reset, cmd.store_byte, count_ff < len_ff, "payload store beyond frame length")
   `ASSERT_IMPLIES(a_index_in_range, clock, reset, rsp_valid_ff && rsp_has_byte_ff, {1'b0, rsp_byte_index_ff} < rsp_payload_length_ff, "byte index outside payload")

endmodule

@@ sv/crc_framed_packet_deframer.sv @@
// Top level of the framed packet deframer with CRC-16 check and register port.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | req_data_byte
//   rsp     | out       | rsp_valid/stall    | status, header fields, payload byte
//   csr     | in/out    | psel/penable/ready | paddr, pwdata, prdata
//
// Every received byte is parsed as it is accepted; the result-producing bytes wait
// only while the output register still holds an untaken result.
// A good frame is read out one payload byte at a time, through the payload memory's
// registered read and then the output register; input stalls then.
// Reset is synchronous and needs no clearing pass: payload entries are read
// only after the current frame has written them.
// A stalled result holds in the output register while parsing goes on.
module crc_framed_packet_deframer
   import cfpd_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [BYTE_W-1:0]           req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [BYTE_W-1:0]           rsp_version,
   output logic [BYTE_W-1:0]           rsp_message_type,
   output logic [BYTE_W-1:0]           rsp_frame_flags,
   output logic [SEQUENCE_W-1:0]       rsp_sequence_res,
   output logic [PAYLOAD_LENGTH_W-1:0] rsp_payload_length,
   output logic [BYTE_W-1:0]           rsp_payload_byte,
   output logic [BYTE_INDEX_W-1:0]     rsp_byte_index,
   output logic                        rsp_has_byte,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   logic [BYTE_W-1:0]        start_first_ff, start_first_in;
   logic [BYTE_W-1:0]        start_second_ff, start_second_in;
   logic [MAX_PAYLOAD_W-1:0] max_payload_ff, max_payload_in;
   logic [REG_INDEX_W-1:0]   reg_index;
   logic                     csr_write;
   cfpd_cmd_type             cmd;
   cfpd_stat_type            stat;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      start_first_in  = start_first_ff;
      start_second_in = start_second_ff;
      max_payload_in  = max_payload_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_START_FIRST:  start_first_in  = csr_pwdata[BYTE_W-1:0];
            REG_START_SECOND: start_second_in = csr_pwdata[BYTE_W-1:0];
            REG_MAX_PAYLOAD:  max_payload_in  = csr_pwdata[MAX_PAYLOAD_W-1:0];
            default: begin
               max_payload_in = max_payload_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_START_FIRST:  csr_prdata = CSR_DATA_W'(start_first_ff);
         REG_START_SECOND: csr_prdata = CSR_DATA_W'(start_second_ff);
         REG_MAX_PAYLOAD:  csr_prdata = CSR_DATA_W'(max_payload_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_first_ff  <= START_FIRST_RESET;
         start_second_ff <= START_SECOND_RESET;
         max_payload_ff  <= MAX_PAYLOAD_RESET;
      end else begin
         start_first_ff  <= start_first_in;
         start_second_ff <= start_second_in;
         max_payload_ff  <= max_payload_in;
      end
   end

   cfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfpd_dp #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .data_byte          (req_data_byte),
      .start_first        (start_first_ff),
      .start_second       (start_second_ff),
      .max_payload        (max_payload_ff),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_version        (rsp_version),
      .rsp_message_type   (rsp_message_type),
      .rsp_frame_flags    (rsp_frame_flags),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_last           (rsp_last)
   );

endmodule

@@ tb/sv/crc_framed_packet_deframer_check.sv @@
// Checker that predicts the deframer's results from accepted bytes and compares them.
module crc_framed_packet_deframer_check
   import cfpd_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [BYTE_W-1:0]           req_data_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [STATUS_W-1:0]         rsp_status,
   input  logic [BYTE_W-1:0]           rsp_version,
   input  logic [BYTE_W-1:0]           rsp_message_type,
   input  logic [BYTE_W-1:0]           rsp_frame_flags,
   input  logic [SEQUENCE_W-1:0]       rsp_sequence_res,
   input  logic [PAYLOAD_LENGTH_W-1:0] rsp_payload_length,
   input  logic [BYTE_W-1:0]           rsp_payload_byte,
   input  logic [BYTE_INDEX_W-1:0]     rsp_byte_index,
   input  logic                        rsp_has_byte,
   input  logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_HEADER, IN_BODY} deframe_phase_type;

   typedef struct packed {
      logic [STATUS_W-1:0]         status;
      logic [BYTE_W-1:0]           version;
      logic [BYTE_W-1:0]           message_type;
      logic [BYTE_W-1:0]           frame_flags;
      logic [SEQUENCE_W-1:0]       seq_num;
      logic [PAYLOAD_LENGTH_W-1:0] payload_length;
      logic [BYTE_W-1:0]           payload_byte;
      logic [BYTE_INDEX_W-1:0]     byte_index;
      logic                        has_byte;
      logic                        last;
   } frame_result_type;

   frame_result_type expected_results[$];
   frame_result_type want;

   logic [BYTE_W-1:0]        sof_first;
   logic [BYTE_W-1:0]        sof_second;
   logic [MAX_PAYLOAD_W-1:0] max_len;

   deframe_phase_type  phase;
   int                 count;
   logic [BYTE_W-1:0]  hdr_ver;
   logic [BYTE_W-1:0]  hdr_typ;
   logic [BYTE_W-1:0]  hdr_flg;
   logic [15:0]        hdr_seq;
   logic [LENGTH_W-1:0] hdr_len;
   logic [15:0]        crc;
   logic [BYTE_W-1:0]  crc_lo;
   logic [BYTE_W-1:0]  body_store [PAYLOAD_DEPTH];

   function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc,
                                                  input logic [BYTE_W-1:0] b);
      logic [15:0] r;
      r = acc ^ {b, 8'h00};
      repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, actual %0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   // Advances the parser by one byte and queues whatever results that byte finishes.
   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      frame_result_type res;
      int span;
      logic [15:0] got_crc;
      res = '0;
      case (phase)
         SEEK_FIRST: begin
            if (b == sof_first) phase = SEEK_SECOND;
         end
         SEEK_SECOND: begin
            // The second start byte wins when both start bytes are equal.
            if (b == sof_second) begin
               phase = IN_HEADER;
               count = 0;
               crc = CRC_INIT;
            end else if (b != sof_first) begin
               phase = SEEK_FIRST;
               count = 0;
            end
         end
         IN_HEADER: begin
            crc = crc_ccitt_step(crc, b);
            case (count)
               0: hdr_ver = b;
               1: hdr_typ = b;
               2: hdr_flg = b;
               3: hdr_seq[7:0] = b;
               4: hdr_seq[15:8] = b;
               5: hdr_len[7:0] = b;
               default: hdr_len[15:8] = b;
            endcase
            span = (max_len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : max_len;
            if (count < 6) begin
               count++;
            end else if (hdr_len > span) begin
               res.status = ST_LEN_ERR;
               res.last = 1'b1;
               expected_results.push_back(res);
               phase = SEEK_FIRST;
               count = 0;
            end else begin
               phase = IN_BODY;
               count = 0;
            end
         end
         default: begin
            span = (hdr_len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : hdr_len;
            if (count < span) begin
               body_store[count] = b;
               crc = crc_ccitt_step(crc, b);
               count++;
            end else if (count == span) begin
               crc_lo = b;
               count++;
            end else begin
               got_crc = {b, crc_lo};
               if (got_crc != crc) begin
                  res.status = ST_CRC_ERR;
                  res.last = 1'b1;
                  expected_results.push_back(res);
               end else begin
                  res.status = ST_GOOD;
                  res.version = hdr_ver;
                  res.message_type = hdr_typ;
                  res.frame_flags = hdr_flg;
                  res.seq_num = hdr_seq;
                  res.payload_length = PAYLOAD_LENGTH_W'(span);
                  if (span == 0) begin
                     res.last = 1'b1;
                     expected_results.push_back(res);
                  end
                  for (int k = 0; k < span; k++) begin
                     res.payload_byte = body_store[k];
                     res.byte_index = BYTE_INDEX_W'(k);
                     res.has_byte = 1'b1;
                     res.last = (k + 1 == span);
                     expected_results.push_back(res);
                  end
               end
               phase = SEEK_FIRST;
               count = 0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sof_first = START_FIRST_RESET;
         sof_second = START_SECOND_RESET;
         max_len = MAX_PAYLOAD_RESET;
         phase = SEEK_FIRST;
         count = 0;
         hdr_ver = '0;
         hdr_typ = '0;
         hdr_flg = '0;
         hdr_seq = '0;
         hdr_len = '0;
         crc = CRC_INIT;
         crc_lo = '0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_START_FIRST:  sof_first = csr_pwdata[BYTE_W-1:0];
               REG_START_SECOND: sof_second = csr_pwdata[BYTE_W-1:0];
               REG_MAX_PAYLOAD:  max_len = csr_pwdata[MAX_PAYLOAD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction: status %0h, last %0h",
                      rsp_status, rsp_last);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("version", 16'(want.version), 16'(rsp_version));
               check_field("message_type", 16'(want.message_type), 16'(rsp_message_type));
               check_field("frame_flags", 16'(want.frame_flags), 16'(rsp_frame_flags));
               check_field("sequence_res", want.seq_num, rsp_sequence_res);
               check_field("payload_length", 16'(want.payload_length),
                           16'(rsp_payload_length));
               check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_payload_byte));
               check_field("byte_index", 16'(want.byte_index), 16'(rsp_byte_index));
               check_field("has_byte", 16'(want.has_byte), 16'(rsp_has_byte));
               check_field("last", 16'(want.last), 16'(rsp_last));
            end
         end
         if (req_valid && !req_stall) deframe_byte(req_data_byte);
      end
      outstanding <= expected_results.size();
   end

endmodule

@@ tb/sv/crc_framed_packet_deframer_test.sv @@
// Top of the deframer testbench: clock, reset, byte and register stimulus, and the verdict.
module crc_framed_packet_deframer_test
   import cfpd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [BYTE_W-1:0]           req_data_byte = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic [BYTE_W-1:0]           rsp_version;
   logic [BYTE_W-1:0]           rsp_message_type;
   logic [BYTE_W-1:0]           rsp_frame_flags;
   logic [SEQUENCE_W-1:0]       rsp_sequence_res;
   logic [PAYLOAD_LENGTH_W-1:0] rsp_payload_length;
   logic [BYTE_W-1:0]           rsp_payload_byte;
   logic [BYTE_INDEX_W-1:0]     rsp_byte_index;
   logic                        rsp_has_byte;
   logic                        rsp_last;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_paddr = '0;
   logic [CSR_DATA_W-1:0]       csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]       csr_prdata;
   logic                        csr_pready;
   int                          fail_count;
   int                          outstanding;

   // Framing settings as last written, used to build well-formed frames.
   logic [BYTE_W-1:0] sof_first = START_FIRST_RESET;
   logic [BYTE_W-1:0] sof_second = START_SECOND_RESET;
   int                len_limit = PAYLOAD_DEPTH_DEFAULT;

   bit calm = 1'b0;
   bit gappy = 1'b1;
   int sent_bytes = 0;
   int stall_left = 0;

   crc_framed_packet_deframer i_dut (.*);
   crc_framed_packet_deframer_check i_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
      if (gappy && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_framing(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                              input int limit);
      write_reg(REG_START_FIRST, first);
      write_reg(REG_START_SECOND, second);
      write_reg(REG_MAX_PAYLOAD, BYTE_W'(limit));
      sof_first = first;
      sof_second = second;
      len_limit = (limit > PAYLOAD_DEPTH_DEFAULT) ? PAYLOAD_DEPTH_DEFAULT : limit;
   endtask

   // Waits until every predicted result has been taken, then lets the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   // A frame whose length exceeds the limit stops after the header, as the block does.
   task automatic send_frame(input logic [BYTE_W-1:0] ver, input logic [BYTE_W-1:0] typ,
                             input logic [BYTE_W-1:0] flg, input logic [15:0] seq,
                             input logic [15:0] len, input bit bad_crc);
      logic [BYTE_W-1:0] hdr [0:6];
      logic [BYTE_W-1:0] b;
      logic [15:0] crc;
      hdr = '{ver, typ, flg, seq[7:0], seq[15:8], len[7:0], len[15:8]};
      crc = CRC_INIT;
      push_byte(sof_first);
      push_byte(sof_second);
      foreach (hdr[k]) begin
         crc = crc16_byte(crc, hdr[k]);
         push_byte(hdr[k]);
      end
      if (len > len_limit) return;
      for (int k = 0; k < len; k++) begin
         b = BYTE_W'($urandom_range(0, 255));
         crc = crc16_byte(crc, b);
         push_byte(b);
      end
      if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      push_byte(crc[7:0]);
      push_byte(crc[15:8]);
   endtask

   task automatic random_frame();
      logic [15:0] len;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) len = 16'($urandom_range(0, (len_limit < 6) ? len_limit : 6));
      else if (pick < 85) len = 16'($urandom_range(0, len_limit));
      else if (pick < 90) len = 16'(len_limit);
      else if (pick < 95) len = 16'(len_limit + 1);
      else len = 16'($urandom_range(65535, len_limit + 1));
      send_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)), SEQUENCE_W'($urandom_range(0, 65535)),
                 len, $urandom_range(0, 9) == 0);
   endtask

   // Mostly well-formed frames, with false starts and line noise mixed in.
   task automatic run_traffic(input int budget);
      int first_byte;
      int pick;
      logic [BYTE_W-1:0] b;
      first_byte = sent_bytes;
      while (sent_bytes - first_byte < budget) begin
         gappy = $urandom_range(0, 2) != 0;
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            random_frame();
         end else if (pick < 90) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == sof_second) b = ~b;
            push_byte(sof_first);
            push_byte(b);
         end else begin
            repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
         end
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_byte(8'h00);
      push_byte(8'hFF);
      // A repeated first start byte keeps waiting for the second one.
      push_byte(sof_first);
      send_frame(8'h00, 8'h00, 8'h00, 16'h0000, 16'd0, 1'b0);
      // Any other byte after the first start byte resumes hunting.
      push_byte(sof_first);
      push_byte(8'h12);
      send_frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'd1, 1'b0);
      send_frame(8'h01, 8'h02, 8'h04, 16'h0102, 16'd65, 1'b0);
      send_frame(8'h80, 8'h40, 8'h20, 16'h8000, 16'hFFFF, 1'b0);
      send_frame(8'h5A, 8'hA5, 8'h3C, 16'h1234, 16'd2, 1'b1);
      send_frame(8'hC3, 8'h7E, 8'h81, 16'hFEDC, 16'd64, 1'b0);
      drain();

      set_framing(8'h00, 8'hFF, 0);
      run_traffic(50);
      set_framing(8'hFF, 8'h00, 64);
      run_traffic(50);
      set_framing(8'h3C, 8'h3C, 17);
      run_traffic(50);
      set_framing(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                  $urandom_range(0, 64));
      run_traffic(50);
      set_framing(START_FIRST_RESET, START_SECOND_RESET, 64);
      calm = 1'b1;
      run_traffic(50);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("status: fail");
      $finish;
   end

endmodule

@@ crc_framed_packet_deframer.f @@
+incdir+sv
sv/cfpd_pkg.sv
sv/cfpd_ctrl.sv
sv/cfpd_dp.sv
sv/crc_framed_packet_deframer.sv
tb/sv/crc_framed_packet_deframer_check.sv
tb/sv/crc_framed_packet_deframer_test.sv
